FILE: src/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants
// Field widths, datapath widths, parameter defaults and the divider bus.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int FIELD_W = 16;  // coordinate field width
  localparam int IDX_W   = 8;   // edge index and hit count width
  localparam int DIFF_W  = 17;  // coordinate difference
  localparam int WIDE_W  = 36;  // cross products and denominator
  localparam int MULB_W  = 18;  // second multiplier operand
  localparam int PROD_W  = WIDE_W + MULB_W;
  localparam int NUM_W   = 48;  // dividend width
  localparam int DEN_W   = WIDE_W;

  localparam int COORD_BITS_DEF   = 16;
  localparam int RATIO_SCALE_DEF  = 100;
  localparam int MAX_VERTICES_DEF = 255;

  typedef struct packed {
    logic             done;  // one-cycle pulse, quotient valid
    logic             neg;   // sign of the quotient
    logic [NUM_W-1:0] mag;   // magnitude, truncated toward zero
  } div_res_t;

  // sign-extend the low cw bits of a coordinate field
  function automatic logic signed [FIELD_W-1:0] sext_coord(
    input logic [FIELD_W-1:0] v, input int cw);
    logic signed [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      r[i] = (i < cw) ? v[i] : v[cw-1];
    end
    return r;
  endfunction

endpackage

FILE: src/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div: bit-serial signed divider
// Restoring radix-2 division on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module spi_div import spi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output div_res_t                res_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q[DEN_W-1:0], acc_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      acc_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_q <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      rem_q <= '0;
      neg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
      acc_q <= {acc_q[NUM_W-2:0], ge};
    end
  end

  assign res_o = '{done: done_q, neg: neg_q, mag: acc_q};

endmodule

FILE: src/segment_polygon_intersection.sv
// ----------------------------------------------------------------------------
// segment_polygon_intersection: query segment against a polyline
// Tests each polyline edge against the query segment, one vertex per item.
// ----------------------------------------------------------------------------
// One item is worked at a time. A first vertex goes from the accepting
// cycle straight to the output stage; any other vertex first goes through
// the differences and the six cross products (one shared multiplier, one
// product a cycle), then up to four quotients from the bit-serial divider,
// then the output stage; an edge that misses early stops sooner. The
// divider sets the rate. A finished item waits in the output register
// while the next item is taken.
module segment_polygon_intersection import spi_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int RATIO_SCALE  = RATIO_SCALE_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] seg_x1_i,
  input  logic signed [FIELD_W-1:0] seg_y1_i,
  input  logic signed [FIELD_W-1:0] seg_x2_i,
  input  logic signed [FIELD_W-1:0] seg_y2_i,
  input  logic signed [FIELD_W-1:0] vert_x_i,
  input  logic signed [FIELD_W-1:0] vert_y_i,
  input  logic                      first_vertex_i,
  input  logic                      last_vertex_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [IDX_W-1:0]          edge_index_o,
  output logic signed [FIELD_W-1:0] cross_x_o,
  output logic signed [FIELD_W-1:0] cross_y_o,
  output logic [IDX_W-1:0]          hit_count_o,
  output logic                      done_res_o
);

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam logic signed [MULB_W-1:0] RS_B = MULB_W'(RATIO_SCALE);
  localparam logic signed [DEN_W-1:0]  RS_D = DEN_W'(RATIO_SCALE);
  localparam logic [NUM_W-1:0]         RS_N = NUM_W'(RATIO_SCALE);
  localparam logic [IDX_W-1:0]         MAX_IDX = IDX_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_DIVR1, ST_DIVR2, ST_DIVX, ST_DIVY, ST_OUT
  } state_e;

  state_e state_q;
  logic [2:0] step_q;
  logic       issued_q;

  logic signed [FIELD_W-1:0] x1_q, y1_q, x2_q, y2_q, vx_q, vy_q;
  logic signed [FIELD_W-1:0] prev_x_q, prev_y_q, cx_q, cy_q;
  logic                      first_q, last_q, hit_q;
  logic [IDX_W-1:0]          vidx_q, hits_q, nidx, nhits;
  logic signed [DIFF_W-1:0]  d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;
  logic signed [WIDE_W-1:0]  t_q, den_q, n1_q, n2_q;
  logic signed [MULB_W-1:0]  r1_q;

  logic signed [WIDE_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [WIDE_W-1:0]  prod_w;
  logic signed [DEN_W-1:0]   div_den;
  logic                      div_start;
  div_res_t                  div_res;
  logic signed [MULB_W-1:0]  q_s;
  logic signed [MULB_W-1:0]  cross_sum;
  logic                      r_bad;
  logic                      out_valid_q, out_free;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL: begin
        case (step_q)
          3'd0: begin mul_a = WIDE_W'(d1x_q); mul_b = MULB_W'(d2y_q); end
          3'd1: begin mul_a = WIDE_W'(d1y_q); mul_b = MULB_W'(d2x_q); end
          3'd2: begin mul_a = WIDE_W'(ey_q);  mul_b = MULB_W'(d2x_q); end
          3'd3: begin mul_a = WIDE_W'(ex_q);  mul_b = MULB_W'(d2y_q); end
          3'd4: begin mul_a = WIDE_W'(ey_q);  mul_b = MULB_W'(d1x_q); end
          default: begin mul_a = WIDE_W'(ex_q); mul_b = MULB_W'(d1y_q); end
        endcase
      end
      ST_DIVR1: begin mul_a = n1_q; mul_b = RS_B; end
      ST_DIVR2: begin mul_a = n2_q; mul_b = RS_B; end
      ST_DIVX:  begin mul_a = WIDE_W'(d1x_q); mul_b = r1_q; end
      ST_DIVY:  begin mul_a = WIDE_W'(d1y_q); mul_b = r1_q; end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_w  = $signed(prod[WIDE_W-1:0]);
  assign div_den = (state_q == ST_DIVX || state_q == ST_DIVY) ? RS_D : den_q;
  assign div_start = !issued_q &&
                     (state_q == ST_DIVR1 || state_q == ST_DIVR2 ||
                      state_q == ST_DIVX  || state_q == ST_DIVY);

  spi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ($signed(prod[NUM_W-1:0])),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  // ratio must lie in 0..RATIO_SCALE
  assign r_bad = (div_res.neg && div_res.mag != '0) || (div_res.mag > RS_N);
  assign q_s   = div_res.neg ? -MULB_W'(div_res.mag) : MULB_W'(div_res.mag);
  assign cross_sum = ((state_q == ST_DIVX) ? MULB_W'(x1_q) : MULB_W'(y1_q)) + q_s;

  assign nidx  = (vidx_q < MAX_IDX) ? vidx_q + 1'b1 : vidx_q;
  assign nhits = (hit_q && hits_q != '1) ? hits_q + 1'b1 : hits_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      vidx_q      <= '0;
      hits_q      <= '0;
    end else begin
      // the output stage reloads the register itself
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            hit_q   <= 1'b0;
            step_q  <= '0;
            state_q <= first_vertex_i ? ST_OUT : ST_DIFF;
          end
        end
        ST_DIFF: state_q <= ST_MUL;
        ST_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd5) begin
            state_q <= (den_q != '0) ? ST_DIVR1 : ST_OUT;
          end
        end
        ST_DIVR1, ST_DIVR2, ST_DIVX, ST_DIVY: begin
          if (div_start) begin
            issued_q <= 1'b1;
          end else if (div_res.done) begin
            issued_q <= 1'b0;
            case (state_q)
              ST_DIVR1: state_q <= r_bad ? ST_OUT : ST_DIVR2;
              ST_DIVR2: state_q <= r_bad ? ST_OUT : ST_DIVX;
              ST_DIVX:  state_q <= ST_DIVY;
              default: begin
                hit_q   <= 1'b1;
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            prev_x_q    <= vx_q;
            prev_y_q    <= vy_q;
            vidx_q      <= first_q ? '0 : nidx;
            hits_q      <= first_q ? '0 : nhits;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x1_q    <= sext_coord(seg_x1_i, CW);
      y1_q    <= sext_coord(seg_y1_i, CW);
      x2_q    <= sext_coord(seg_x2_i, CW);
      y2_q    <= sext_coord(seg_y2_i, CW);
      vx_q    <= sext_coord(vert_x_i, CW);
      vy_q    <= sext_coord(vert_y_i, CW);
      first_q <= first_vertex_i;
      last_q  <= last_vertex_i;
    end
    if (state_q == ST_DIFF) begin
      d1x_q <= DIFF_W'(x2_q) - DIFF_W'(x1_q);
      d1y_q <= DIFF_W'(y2_q) - DIFF_W'(y1_q);
      d2x_q <= DIFF_W'(vx_q) - DIFF_W'(prev_x_q);
      d2y_q <= DIFF_W'(vy_q) - DIFF_W'(prev_y_q);
      ex_q  <= DIFF_W'(x1_q) - DIFF_W'(prev_x_q);
      ey_q  <= DIFF_W'(y1_q) - DIFF_W'(prev_y_q);
    end
    if (state_q == ST_MUL) begin
      case (step_q)
        3'd1:    den_q <= t_q - prod_w;
        3'd3:    n1_q  <= t_q - prod_w;
        3'd5:    n2_q  <= t_q - prod_w;
        default: t_q   <= prod_w;
      endcase
    end
    if (div_res.done) begin
      if (state_q == ST_DIVR1) r1_q <= MULB_W'(div_res.mag);
      if (state_q == ST_DIVX)  cx_q <= cross_sum[FIELD_W-1:0];
      if (state_q == ST_DIVY)  cy_q <= cross_sum[FIELD_W-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      hit_o        <= hit_q;
      edge_index_o <= hit_q ? nidx : '0;
      cross_x_o    <= hit_q ? cx_q : '0;
      cross_y_o    <= hit_q ? cy_q : '0;
      hit_count_o  <= first_q ? '0 : nhits;
      done_res_o   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> edge_index_o != '0 && hit_count_o != '0)
    else $error("hit reported with zero index or count");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> edge_index_o == '0 && cross_x_o == '0 &&
    cross_y_o == '0)
    else $error("miss carries nonzero fields");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIVR1 || state_q == ST_DIVR2 ||
    state_q == ST_DIVX || state_q == ST_DIVY)
    else $error("quotient arrived outside a divide step");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_valid_q && out_stall_i |=> out_valid_q &&
    state_q == ST_OUT)
    else $error("result loaded over a waiting item");

endmodule

FILE: tb/tb_segment_polygon_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_polygon_intersection: testbench for the segment/polyline tester
// Drives directed and random polylines through the block with random gaps
// and receiver stalls, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_segment_polygon_intersection;
  import spi_pkg::*;

  typedef struct {
    logic signed [FIELD_W-1:0] x1, y1, x2, y2, vx, vy;
    logic                      first, last;
    logic                      drain;  // hold off until all results are in
  } vertex_t;

  typedef struct packed {
    logic                      hit;
    logic [IDX_W-1:0]          edge_index;
    logic signed [FIELD_W-1:0] cross_x, cross_y;
    logic [IDX_W-1:0]          hit_count;
    logic                      done_res;
  } crossing_t;

  localparam int SCALE = RATIO_SCALE_DEF;
  localparam int TAIL  = 400;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [FIELD_W-1:0] seg_x1_i, seg_y1_i, seg_x2_i, seg_y2_i, vert_x_i, vert_y_i;
  logic first_vertex_i, last_vertex_i;
  logic hit_o, done_res_o;
  logic [IDX_W-1:0] edge_index_o, hit_count_o;
  logic signed [FIELD_W-1:0] cross_x_o, cross_y_o;

  segment_polygon_intersection dut (.*);

  vertex_t   pending_vertices[$];
  crossing_t expected_crossings[$];
  bit        failed = 0;
  bit        stimulus_done = 0;
  int        items_taken = 0;
  int        results_seen = 0;
  int        hold_cycles = 0;

  // predictor state
  logic signed [FIELD_W-1:0] prev_x = '0, prev_y = '0;
  logic [IDX_W-1:0]          vertex_index = '0, hit_total = '0;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  task automatic predict_crossing(input vertex_t v);
    crossing_t r;
    longint d1x, d1y, d2x, d2y, den, ex, ey, n1, n2, r1, r2;
    r = '0;
    r.done_res = v.last;
    if (v.first) begin
      vertex_index = '0;
      hit_total = '0;
    end else begin
      if (vertex_index < MAX_VERTICES_DEF) vertex_index++;
      d1x = longint'(v.x2) - longint'(v.x1);
      d1y = longint'(v.y2) - longint'(v.y1);
      d2x = longint'(v.vx) - longint'(prev_x);
      d2y = longint'(v.vy) - longint'(prev_y);
      den = d1x * d2y - d1y * d2x;
      if (den != 0) begin
        ey = longint'(v.y1) - longint'(prev_y);
        ex = longint'(v.x1) - longint'(prev_x);
        n1 = ey * d2x - ex * d2y;
        n2 = ey * d1x - ex * d1y;
        r1 = (SCALE * n1) / den;
        r2 = (SCALE * n2) / den;
        if (r1 >= 0 && r1 <= SCALE && r2 >= 0 && r2 <= SCALE) begin
          r.hit = 1'b1;
          r.edge_index = vertex_index;
          r.cross_x = FIELD_W'(longint'(v.x1) + (r1 * d1x) / SCALE);
          r.cross_y = FIELD_W'(longint'(v.y1) + (r1 * d1y) / SCALE);
          if (hit_total != 8'hFF) hit_total++;
        end
      end
    end
    prev_x = v.vx;
    prev_y = v.vy;
    r.hit_count = hit_total;
    expected_crossings.push_back(r);
  endtask

  task automatic add_vertex(input int x1, y1, x2, y2, vx, vy,
                            input bit first, last, drain = 0);
    vertex_t v;
    v.x1 = FIELD_W'(x1); v.y1 = FIELD_W'(y1);
    v.x2 = FIELD_W'(x2); v.y2 = FIELD_W'(y2);
    v.vx = FIELD_W'(vx); v.vy = FIELD_W'(vy);
    v.first = first; v.last = last; v.drain = drain;
    pending_vertices.push_back(v);
  endtask

  function automatic int rand_coord(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // driver
  vertex_t cur_vertex;
  int      send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      seg_x1_i       <= '0;
      seg_y1_i       <= '0;
      seg_x2_i       <= '0;
      seg_y2_i       <= '0;
      vert_x_i       <= '0;
      vert_y_i       <= '0;
      first_vertex_i <= 1'b0;
      last_vertex_i  <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_crossing(cur_vertex);
        items_taken++;
        next_valid = 1'b0;
        send_gap = ((items_taken / 64) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_vertices.size() > 0 &&
                     (!pending_vertices[0].drain || expected_crossings.size() == 0)) begin
          cur_vertex = pending_vertices.pop_front();
          seg_x1_i <= cur_vertex.x1;
          seg_y1_i <= cur_vertex.y1;
          seg_x2_i <= cur_vertex.x2;
          seg_y2_i <= cur_vertex.y2;
          vert_x_i <= cur_vertex.vx;
          vert_y_i <= cur_vertex.vy;
          first_vertex_i <= cur_vertex.first;
          last_vertex_i <= cur_vertex.last;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // long receiver hold-off while the sender keeps going
  always @(posedge clk_i) begin
    if (results_seen == 500 && hold_cycles == 0) hold_cycles <= 3000;
    else if (hold_cycles > 1) hold_cycles <= hold_cycles - 1;
  end

  // monitor
  int recv_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t got, want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {hit_o, edge_index_o, cross_x_o, cross_y_o, hit_count_o, done_res_o};
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected item hit=%0b idx=%0d x=%0d y=%0d cnt=%0d done=%0b",
                   $time, got.hit, got.edge_index, got.cross_x, got.cross_y,
                   got.hit_count, got.done_res);
          failed = 1;
        end else begin
          want = expected_crossings.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected hit=%0b idx=%0d x=%0d y=%0d cnt=%0d done=%0b",
                     $time, want.hit, want.edge_index, want.cross_x, want.cross_y,
                     want.hit_count, want.done_res);
            $display("%0t:          actual   hit=%0b idx=%0d x=%0d y=%0d cnt=%0d done=%0b",
                     $time, got.hit, got.edge_index, got.cross_x, got.cross_y,
                     got.hit_count, got.done_res);
            failed = 1;
          end
        end
        results_seen++;
        recv_wait = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait > 0) || (hold_cycles > 1);
    end
  end

  initial begin
    int n, span, x1, y1, x2, y2;
    rst_ni = 1'b0;

    // no first vertex after reset: edge starts at the origin
    add_vertex(-100, 0, 100, 0, 0, 50, 0, 0);
    add_vertex(-100, 0, 100, 0, 0, -50, 1, 0);
    add_vertex(-100, 0, 100, 0, 0, 50, 0, 0);
    add_vertex(-100, 0, 100, 0, 10, 50, 0, 0);      // parallel
    add_vertex(-100, 0, 100, 0, 10, -50, 0, 0);
    add_vertex(-100, 0, 100, 0, 300, 70, 0, 1);     // misses past the end
    add_vertex(-100, 0, 100, 0, 300, -70, 0, 0);    // goes on after last vertex
    add_vertex(-100, 0, 100, 0, 50, 0, 0, 1, 1);    // ends on the segment
    // extremes
    add_vertex(-32768, -32768, 32767, 32767, -32768, 32767, 1, 0);
    add_vertex(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0);
    add_vertex(-32768, -32768, 32767, 32767, 32767, 32767, 0, 0);
    add_vertex(32767, -32768, -32768, 32767, -32768, -32768, 0, 1);
    // zero-length query segment
    add_vertex(5, 5, 5, 5, 0, 0, 1, 0);
    add_vertex(5, 5, 5, 5, 10, 10, 0, 1);
    // crossing exactly at the segment end
    add_vertex(0, 0, 100, 0, 100, -10, 1, 0);
    add_vertex(0, 0, 100, 0, 100, 10, 0, 1);
    // degenerate edge, repeated vertex
    add_vertex(0, -5, 0, 5, 3, 3, 1, 0);
    add_vertex(0, -5, 0, 5, 3, 3, 0, 1);

    // long zigzag: every edge hits, index and hit count saturate
    for (int i = 0; i < 300; i++)
      add_vertex(-1000, 0, 1000, 0, -900 + 5 * i, (i % 2) ? 10 : -10, i == 0, i == 299);

    // random polylines, mostly well-formed
    while (pending_vertices.size() < 1150) begin
      span = ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(4, 2000);
      x1 = rand_coord(span); y1 = rand_coord(span);
      x2 = rand_coord(span); y2 = rand_coord(span);
      n = $urandom_range(2, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          add_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        else
          add_vertex(x1, y1, x2, y2, rand_coord(span), rand_coord(span),
                     i == 0, i == n - 1, i == 0 && $urandom_range(0, 30) == 0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_vertices.size() == 0 && !in_valid_i);
    wait (expected_crossings.size() == 0);
    repeat (TAIL) @(posedge clk_i);
    if (!failed && expected_crossings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
